/* sv/hdo_pkg.sv */
package hdo_pkg;

  localparam int UCODE_DEPTH = 20;
  localparam int UPC_W       = $clog2(UCODE_DEPTH);

  localparam logic [UPC_W-1:0] UPC_SINE = UPC_W'(0);
  localparam logic [UPC_W-1:0] UPC_DONE = UPC_W'(19);

  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026995;
  localparam logic [30:0] SIN_C9 = 31'd172272;

  localparam logic [15:0] HARM2_Q15      = 16'd9830;
  localparam logic [15:0] HARM3_Q15      = 16'd4915;
  localparam logic [15:0] TREM_DEPTH_Q15 = 16'd4915;
  localparam logic [15:0] TREM_BIAS_Q15  = 16'd27853;
  localparam logic [31:0] LFO_RESET      = 32'd8948;

  typedef enum logic [1:0] {
    REG_ENABLE,
    REG_TUNING,
    REG_VELOCITY,
    REG_LFO_TUNING
  } reg_idx_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_TT,
    MUL_T2C9,
    MUL_T2A,
    MUL_TA,
    MUL_H2,
    MUL_H3,
    MUL_TREM,
    MUL_GV,
    MUL_DRONE
  } mul_op_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_SETUP,
    WB_T2,
    WB_A7,
    WB_A5,
    WB_A3,
    WB_A1,
    WB_SINE,
    WB_H2,
    WB_H3,
    WB_GAIN,
    WB_DONE
  } wb_op_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_OFF,
    JMP_LOOP
  } jmp_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  typedef struct packed {
    mul_op_t          mul;
    wb_op_t           wb;
    jmp_op_t          jmp;
    logic [UPC_W-1:0] target;
    logic             last;
  } ucode_word_t;

  typedef struct packed {
    logic    load;
    mul_op_t mul;
    wb_op_t  wb;
  } ctrl_t;

  typedef struct packed {
    logic enable;
    logic sine_last;
    logic out_full;
  } status_t;

endpackage

/* sv/hdo_sequencer.sv */
module hdo_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  hdo_pkg::status_t status,
  output hdo_pkg::ctrl_t   ctrl
);

  function automatic hdo_pkg::ucode_word_t ucode(input logic [hdo_pkg::UPC_W-1:0] pc);
    hdo_pkg::ucode_word_t w;
    w = '{mul: hdo_pkg::MUL_NONE, wb: hdo_pkg::WB_NONE, jmp: hdo_pkg::JMP_NONE,
          target: hdo_pkg::UPC_SINE, last: 1'b0};
    unique case (pc)
      5'd0: begin
        w.wb     = hdo_pkg::WB_SETUP;
        w.jmp    = hdo_pkg::JMP_OFF;
        w.target = hdo_pkg::UPC_DONE;
      end
      5'd1:  w.mul = hdo_pkg::MUL_TT;
      5'd2:  w.wb  = hdo_pkg::WB_T2;
      5'd3:  w.mul = hdo_pkg::MUL_T2C9;
      5'd4:  w.wb  = hdo_pkg::WB_A7;
      5'd5:  w.mul = hdo_pkg::MUL_T2A;
      5'd6:  w.wb  = hdo_pkg::WB_A5;
      5'd7:  w.mul = hdo_pkg::MUL_T2A;
      5'd8:  w.wb  = hdo_pkg::WB_A3;
      5'd9:  w.mul = hdo_pkg::MUL_T2A;
      5'd10: w.wb  = hdo_pkg::WB_A1;
      5'd11: w.mul = hdo_pkg::MUL_TA;
      5'd12: begin
        w.wb     = hdo_pkg::WB_SINE;
        w.jmp    = hdo_pkg::JMP_LOOP;
        w.target = hdo_pkg::UPC_SINE;
      end
      5'd13: w.mul = hdo_pkg::MUL_H2;
      5'd14: begin
        w.wb  = hdo_pkg::WB_H2;
        w.mul = hdo_pkg::MUL_H3;
      end
      5'd15: begin
        w.wb  = hdo_pkg::WB_H3;
        w.mul = hdo_pkg::MUL_TREM;
      end
      5'd16: w.wb  = hdo_pkg::WB_GAIN;
      5'd17: w.mul = hdo_pkg::MUL_GV;
      5'd18: w.mul = hdo_pkg::MUL_DRONE;
      5'd19: begin
        w.wb   = hdo_pkg::WB_DONE;
        w.last = 1'b1;
      end
      default: w.last = 1'b1;
    endcase
    return w;
  endfunction

  hdo_pkg::seq_state_t       state_r, state_nxt;
  logic [hdo_pkg::UPC_W-1:0] step_r, step_nxt;
  hdo_pkg::ucode_word_t      cw;
  logic                      hold;
  logic                      taken;

  assign cw   = ucode(step_r);
  assign hold = (state_r == hdo_pkg::ST_RUN) && (cw.wb == hdo_pkg::WB_DONE) && status.out_full;

  always_comb begin
    unique case (cw.jmp)
      hdo_pkg::JMP_OFF:  taken = !status.enable;
      hdo_pkg::JMP_LOOP: taken = !status.sine_last;
      default:           taken = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      hdo_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = hdo_pkg::ST_RUN;
          step_nxt  = hdo_pkg::UPC_SINE;
        end
      end
      hdo_pkg::ST_RUN: begin
        priority if (hold) begin
          step_nxt = step_r;
        end else if (cw.last) begin
          state_nxt = hdo_pkg::ST_IDLE;
        end else if (taken) begin
          step_nxt = cw.target;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ctrl.load = 1'b0;
    ctrl.mul  = hdo_pkg::MUL_NONE;
    ctrl.wb   = hdo_pkg::WB_NONE;
    unique case (state_r)
      hdo_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      hdo_pkg::ST_RUN: begin
        if (!hold) begin
          ctrl.mul = cw.mul;
          ctrl.wb  = cw.wb;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hdo_pkg::ST_IDLE;
      step_r  <= hdo_pkg::UPC_SINE;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hdo_pkg::ST_RUN |-> step_r < hdo_pkg::UPC_W'(hdo_pkg::UCODE_DEPTH))
    else $error("step counter outside program");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wb == hdo_pkg::WB_DONE |=> state_r == hdo_pkg::ST_IDLE)
    else $error("sequencer did not return to idle after result");

  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    hold |=> $stable(step_r) && state_r == hdo_pkg::ST_RUN)
    else $error("step moved while result stalled");

endmodule

/* sv/hdo_datapath.sv */
module hdo_datapath #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [15:0] in_mix_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_mix_out,
  input  hdo_pkg::ctrl_t     ctrl,
  output hdo_pkg::status_t   status
);

  localparam int KW = SINE_TABLE_BITS - 2;
  localparam logic [KW:0] QUARTER = (KW + 1)'(1) << KW;

  logic               enable_r;
  logic [31:0]        tuning_r;
  logic [15:0]        velocity_r;
  logic [31:0]        lfo_tuning_r;
  logic [31:0]        tone_phase_r;
  logic [31:0]        trem_phase_r;

  logic signed [15:0] mix_r;
  logic [1:0]         sidx_r;
  logic [30:0]        t_r, t2_r, a_r;
  logic               neg_r;
  logic signed [15:0] s_r [4];
  logic signed [17:0] h_r;
  logic [15:0]        g_r;
  logic signed [63:0] prod_r;
  logic               out_valid_r;
  logic signed [15:0] out_r;

  logic [31:0]        ph;
  logic [KW-1:0]      k_raw;
  logic [KW:0]        k;
  logic signed [31:0] mul_a, mul_b;
  logic [30:0]        shr30;
  logic [31:0]        sine_rnd;
  logic [16:0]        sine_mag;
  logic [15:0]        sine_cap;
  logic signed [63:0] rnd15, rnd30;
  logic signed [17:0] r15;
  logic signed [18:0] drone;
  logic signed [19:0] mix_sum;
  logic signed [15:0] mix_sat;

  always_comb begin
    unique case (sidx_r)
      2'd0: ph = tone_phase_r;
      2'd1: ph = {tone_phase_r[30:0], 1'b0};
      2'd2: ph = tone_phase_r + {tone_phase_r[30:0], 1'b0};
      default: ph = trem_phase_r;
    endcase
    k_raw = ph[29 -: KW];
    k     = ph[30] ? (QUARTER - {1'b0, k_raw}) : {1'b0, k_raw};
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.mul)
      hdo_pkg::MUL_TT: begin
        mul_a = {1'b0, t_r};
        mul_b = {1'b0, t_r};
      end
      hdo_pkg::MUL_T2C9: begin
        mul_a = {1'b0, t2_r};
        mul_b = {1'b0, hdo_pkg::SIN_C9};
      end
      hdo_pkg::MUL_T2A: begin
        mul_a = {1'b0, t2_r};
        mul_b = {1'b0, a_r};
      end
      hdo_pkg::MUL_TA: begin
        mul_a = {1'b0, t_r};
        mul_b = {1'b0, a_r};
      end
      hdo_pkg::MUL_H2: begin
        mul_a = {{16{s_r[1][15]}}, s_r[1]};
        mul_b = {16'd0, hdo_pkg::HARM2_Q15};
      end
      hdo_pkg::MUL_H3: begin
        mul_a = {{16{s_r[2][15]}}, s_r[2]};
        mul_b = {16'd0, hdo_pkg::HARM3_Q15};
      end
      hdo_pkg::MUL_TREM: begin
        mul_a = {{16{s_r[3][15]}}, s_r[3]};
        mul_b = {16'd0, hdo_pkg::TREM_DEPTH_Q15};
      end
      hdo_pkg::MUL_GV: begin
        mul_a = {16'd0, g_r};
        mul_b = {16'd0, velocity_r};
      end
      hdo_pkg::MUL_DRONE: begin
        mul_a = {{14{h_r[17]}}, h_r};
        mul_b = {1'b0, prod_r[30:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    shr30    = prod_r[60:30];
    sine_rnd = {1'b0, shr30} + 32'd16384;
    sine_mag = sine_rnd[31:15];
    sine_cap = (sine_mag > 17'd32767) ? 16'd32767 : sine_mag[15:0];
    rnd15    = prod_r + 64'sd16384;
    r15      = rnd15[32:15];
    rnd30    = prod_r + 64'sd536870912;
    drone    = rnd30[48:30];
    mix_sum  = {{4{mix_r[15]}}, mix_r} + {drone[18], drone};
    priority if (mix_sum > 20'sd32767) begin
      mix_sat = 16'sh7fff;
    end else if (mix_sum < -20'sd32768) begin
      mix_sat = -16'sh8000;
    end else begin
      mix_sat = mix_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      tuning_r     <= '0;
      velocity_r   <= '0;
      lfo_tuning_r <= hdo_pkg::LFO_RESET;
    end else if (cfg_valid) begin
      unique case (hdo_pkg::reg_idx_t'(cfg_index))
        hdo_pkg::REG_ENABLE:     enable_r     <= cfg_data[0];
        hdo_pkg::REG_TUNING:     tuning_r     <= cfg_data;
        hdo_pkg::REG_VELOCITY:   velocity_r   <= cfg_data[15:0];
        hdo_pkg::REG_LFO_TUNING: lfo_tuning_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_phase_r <= '0;
      trem_phase_r <= '0;
      out_valid_r  <= 1'b0;
      sidx_r       <= '0;
    end else begin
      if (ctrl.load) begin
        sidx_r <= '0;
      end
      if (ctrl.wb == hdo_pkg::WB_SINE) begin
        sidx_r <= sidx_r + 1'b1;
      end
      if (ctrl.wb == hdo_pkg::WB_DONE) begin
        out_valid_r <= 1'b1;
        if (enable_r) begin
          tone_phase_r <= tone_phase_r + tuning_r;
          trem_phase_r <= trem_phase_r + lfo_tuning_r;
        end
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mix_r <= in_mix_in;
    end
    if (ctrl.mul != hdo_pkg::MUL_NONE) begin
      prod_r <= mul_a * mul_b;
    end
    unique case (ctrl.wb)
      hdo_pkg::WB_SETUP: begin
        t_r   <= {k, {(32 - SINE_TABLE_BITS){1'b0}}};
        neg_r <= ph[31];
      end
      hdo_pkg::WB_T2:   t2_r <= shr30;
      hdo_pkg::WB_A7:   a_r  <= hdo_pkg::SIN_C7 - shr30;
      hdo_pkg::WB_A5:   a_r  <= hdo_pkg::SIN_C5 - shr30;
      hdo_pkg::WB_A3:   a_r  <= hdo_pkg::SIN_C3 - shr30;
      hdo_pkg::WB_A1:   a_r  <= hdo_pkg::SIN_C1 - shr30;
      hdo_pkg::WB_SINE: s_r[sidx_r] <= neg_r ? -signed'(sine_cap) : signed'(sine_cap);
      hdo_pkg::WB_H2:   h_r  <= {{2{s_r[0][15]}}, s_r[0]} + r15;
      hdo_pkg::WB_H3:   h_r  <= h_r + r15;
      hdo_pkg::WB_GAIN: g_r  <= 16'(signed'({2'b00, hdo_pkg::TREM_BIAS_Q15}) + r15);
      hdo_pkg::WB_DONE: out_r <= enable_r ? mix_sat : mix_r;
      default: begin
      end
    endcase
  end

  assign status.enable    = enable_r;
  assign status.sine_last = (sidx_r == 2'd3);
  assign status.out_full  = out_valid_r && !out_ready;
  assign out_valid        = out_valid_r;
  assign out_mix_out      = out_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wb == hdo_pkg::WB_DONE |-> !out_valid_r || out_ready)
    else $error("pending result overwritten");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.wb == hdo_pkg::WB_DONE))
    else $error("result raised without completion step");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wb != hdo_pkg::WB_DONE |=> $stable(tone_phase_r) && $stable(trem_phase_r))
    else $error("phase moved outside completion step");

endmodule

/* sv/harmonic_drone_oscillator_unit.sv */
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     in_mix_in (s16)
// out       output     out_valid / out_ready   out_mix_out (s16)
// cfg       input      cfg_valid / cfg_ready   cfg_index (2), cfg_data (32)
//
// An enabled transaction runs from acceptance to result as four passes of the thirteen-step
// sine routine through the single shared multiplier, then seven combine steps. A disabled
// transaction jumps from setup to the final step. Synchronous active-low reset clears the
// phases, loads register defaults and empties the output register. A stalled result holds
// the final microcode step; a new transaction is accepted while the result waits.
module harmonic_drone_oscillator_unit #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_mix_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_mix_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  hdo_pkg::ctrl_t   ctrl;
  hdo_pkg::status_t status;

  assign cfg_ready = 1'b1;

  hdo_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  hdo_datapath #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_mix_in   (in_mix_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_mix_out (out_mix_out),
    .ctrl        (ctrl),
    .status      (status)
  );

endmodule

/* tb/sv/harmonic_drone_oscillator_unit_tb.sv */
`timescale 1ns / 1ps

module harmonic_drone_oscillator_unit_tb;

  localparam int SINE_BITS      = 10;
  localparam int QUARTER        = 1 << (SINE_BITS - 2);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 600;
  localparam int TARGET_ITEMS   = 1900;

  localparam longint unsigned C1 = hdo_pkg::SIN_C1;
  localparam longint unsigned C3 = hdo_pkg::SIN_C3;
  localparam longint unsigned C5 = hdo_pkg::SIN_C5;
  localparam longint unsigned C7 = hdo_pkg::SIN_C7;
  localparam longint unsigned C9 = hdo_pkg::SIN_C9;

  localparam longint W_HARM2      = longint'(hdo_pkg::HARM2_Q15);
  localparam longint W_HARM3      = longint'(hdo_pkg::HARM3_Q15);
  localparam longint W_TREM_DEPTH = longint'(hdo_pkg::TREM_DEPTH_Q15);
  localparam longint W_TREM_BIAS  = longint'(hdo_pkg::TREM_BIAS_Q15);

  typedef struct {
    hdo_pkg::reg_idx_t idx;
    logic [31:0]       data;
  } cfg_write_t;

  class drone_scoreboard;
    bit                 en;
    bit [31:0]          step;
    bit [15:0]          vel;
    bit [31:0]          lfo_step = hdo_pkg::LFO_RESET;
    bit [31:0]          tone_ph;
    bit [31:0]          trem_ph;
    logic signed [15:0] mix_expected_q[$];
    int                 mismatches;

    function void write_reg(hdo_pkg::reg_idx_t idx, logic [31:0] d);
      case (idx)
        hdo_pkg::REG_ENABLE:     en = d[0];
        hdo_pkg::REG_TUNING:     step = d;
        hdo_pkg::REG_VELOCITY:   vel = d[15:0];
        hdo_pkg::REG_LFO_TUNING: lfo_step = d;
        default: ;
      endcase
    endfunction

    function longint round_shift(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint quarter_amp(int unsigned k);
      longint unsigned t, t2, a, s;
      t  = longint'(k) << (32 - SINE_BITS);
      t2 = (t * t) >> 30;
      a  = C7 - ((t2 * C9) >> 30);
      a  = C5 - ((t2 * a) >> 30);
      a  = C3 - ((t2 * a) >> 30);
      a  = C1 - ((t2 * a) >> 30);
      s  = (t * a) >> 30;
      s  = (s + (64'd1 << 14)) >> 15;
      if (s > 64'd32767) s = 64'd32767;
      return longint'(s);
    endfunction

    function longint sine_at(bit [31:0] ph);
      int unsigned idx, quad, k;
      longint      mag;
      idx  = ph >> (32 - SINE_BITS);
      quad = idx >> (SINE_BITS - 2);
      k    = idx & (QUARTER - 1);
      if (quad & 1) k = QUARTER - k;
      mag = quarter_amp(k);
      return (quad & 2) ? -mag : mag;
    endfunction

    function void note_mix(logic signed [15:0] m);
      longint    acc, s1, s2, s3, sq, h, gain, drone;
      bit [31:0] p2, p3;
      acc = m;
      if (en) begin
        p2    = tone_ph * 32'd2;
        p3    = tone_ph * 32'd3;
        s1    = sine_at(tone_ph);
        s2    = sine_at(p2);
        s3    = sine_at(p3);
        sq    = sine_at(trem_ph);
        h     = s1 + round_shift(s2 * W_HARM2, 15) + round_shift(s3 * W_HARM3, 15);
        gain  = W_TREM_BIAS + round_shift(sq * W_TREM_DEPTH, 15);
        drone = round_shift(h * gain * longint'(vel), 30);
        acc   = acc + drone;
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        tone_ph = tone_ph + step;
        trem_ph = trem_ph + lfo_step;
      end
      mix_expected_q.push_back(acc[15:0]);
    endfunction

    function void check_mix(logic signed [15:0] got);
      logic signed [15:0] want;
      if (mix_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: mix_out %0d", got);
        return;
      end
      want = mix_expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mix_out mismatch: expected %0d, got %0d", want, got);
      end
    endfunction

    function int pending();
      return mix_expected_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_mix_in;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_mix_out;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;

  drone_scoreboard sb = new();

  int quiet_cycles;
  bit hold_req;
  bit hold_done;
  int hold_left;
  int rx_mode;
  int rx_left;

  harmonic_drone_oscillator_unit #(
    .SINE_TABLE_BITS(SINE_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mix_in(in_mix_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_mix_out(out_mix_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_mix(out_mix_out);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold off once for a long stretch on request, otherwise follow random segments
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_left = $urandom_range(10, 200);
        rx_mode = $urandom_range(0, 3);
      end
      rx_left--;
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= $urandom_range(0, 1);
        2:       out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic program_regs(input cfg_write_t writes[$]);
    foreach (writes[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= writes[i].idx;
      cfg_data  <= writes[i].data;
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(writes[i].idx, writes[i].data);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic stream_mix(input logic signed [15:0] vals[$], input bit gapless);
    int burst_left;
    int gap;
    burst_left = $urandom_range(1, 30);
    foreach (vals[i]) begin
      in_valid  <= 1'b1;
      in_mix_in <= vals[i];
      do @(posedge clk); while (!in_ready);
      sb.note_mix(vals[i]);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap = (gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    cfg_write_t         writes[$];
    logic signed [15:0] vals[$];
    int                 items_sent;
    int                 phase;
    int                 n;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_mix_in = '0;
    cfg_valid = 1'b0;
    cfg_index = hdo_pkg::REG_ENABLE;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    vals = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'h5555, 16'hAAAA};
    stream_mix(vals, 1'b0);
    wait_drained();

    writes = '{'{hdo_pkg::REG_ENABLE, 32'd1}, '{hdo_pkg::REG_TUNING, 32'h4000_0000},
               '{hdo_pkg::REG_VELOCITY, 32'd32768}};
    program_regs(writes);
    vals = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd1000, -16'sd1000};
    stream_mix(vals, 1'b0);
    wait_drained();

    writes = '{'{hdo_pkg::REG_VELOCITY, 32'd65535}, '{hdo_pkg::REG_TUNING, 32'h1555_5555},
               '{hdo_pkg::REG_LFO_TUNING, 32'hFFFF_FFFF}};
    program_regs(writes);
    vals = '{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd0, 16'sd12345};
    stream_mix(vals, 1'b0);
    wait_drained();

    writes = '{'{hdo_pkg::REG_ENABLE, 32'd0}};
    program_regs(writes);
    vals = '{16'sd7, -16'sd7};
    stream_mix(vals, 1'b0);
    wait_drained();

    writes = '{'{hdo_pkg::REG_ENABLE, 32'd1}, '{hdo_pkg::REG_VELOCITY, 32'd0},
               '{hdo_pkg::REG_TUNING, 32'hFFFF_FFFF},
               '{hdo_pkg::REG_LFO_TUNING, 32'h8000_0000}};
    program_regs(writes);
    vals = '{-16'sd32768, 16'sd32767, 16'sd1};
    stream_mix(vals, 1'b0);
    items_sent = 22;

    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      wait_drained();
      writes = {};
      if ($urandom_range(0, 3) != 0)
        writes.push_back('{hdo_pkg::REG_ENABLE,
                           ($urandom_range(0, 5) != 0) ? 32'd1 : 32'd0});
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0:       writes.push_back('{hdo_pkg::REG_TUNING, 32'd0});
          1:       writes.push_back('{hdo_pkg::REG_TUNING, 32'h8000_0000});
          2:       writes.push_back('{hdo_pkg::REG_TUNING, 32'hFFFF_FFFF});
          3:       writes.push_back('{hdo_pkg::REG_TUNING, $urandom_range(0, 1 << 16)});
          default: writes.push_back('{hdo_pkg::REG_TUNING, $urandom});
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 4))
          0:       writes.push_back('{hdo_pkg::REG_VELOCITY, 32'd0});
          1:       writes.push_back('{hdo_pkg::REG_VELOCITY, 32'd32768});
          2:       writes.push_back('{hdo_pkg::REG_VELOCITY, 32'd65535});
          3:       writes.push_back('{hdo_pkg::REG_VELOCITY, $urandom_range(0, 32768)});
          default: writes.push_back('{hdo_pkg::REG_VELOCITY, $urandom_range(0, 65535)});
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 4))
          0:       writes.push_back('{hdo_pkg::REG_LFO_TUNING, 32'd0});
          1:       writes.push_back('{hdo_pkg::REG_LFO_TUNING, hdo_pkg::LFO_RESET});
          2:       writes.push_back('{hdo_pkg::REG_LFO_TUNING, 32'h8000_0000});
          3:       writes.push_back('{hdo_pkg::REG_LFO_TUNING, 32'hFFFF_FFFF});
          default: writes.push_back('{hdo_pkg::REG_LFO_TUNING, $urandom});
        endcase
      end
      if (writes.size() == 0) writes.push_back('{hdo_pkg::REG_ENABLE, 32'd1});
      program_regs(writes);

      n = $urandom_range(40, 200);
      vals = {};
      repeat (n) begin
        case ($urandom_range(0, 9))
          0:       vals.push_back(-16'sd32768);
          1:       vals.push_back(16'sd32767);
          2:       vals.push_back(16'($urandom_range(0, 200)) - 16'sd100);
          default: vals.push_back(16'($urandom_range(0, 65535)));
        endcase
      end
      if (phase == 3) hold_req = 1'b1;
      stream_mix(vals, phase == 3);
      items_sent += n;
      phase++;
    end

    wait_drained();
    repeat (64) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
